### hdl/ltc_pkg.sv
// shared types, widths, constants and helper functions of the topological charge unit
package ltc_pkg;

  // spin component format: signed, F fraction bits
  localparam int CB       = 16;
  localparam int F        = CB - 2;
  localparam int SPIN_W   = 48;

  // default CORDIC depth
  localparam int CORDIC_STAGES_DEF = 16;

  // lattice path widths
  localparam int DOT_W    = 2 * CB + 2;
  localparam int CRS_W    = CB + 3;
  localparam int NUM_W    = 2 * CB + 5;
  localparam int DEN_W    = 2 * CB + 4;
  localparam int CW       = 2 * CB + 8;
  localparam int ANG_W    = 34;
  localparam int SUM_W    = ANG_W + 2;
  localparam int RND_SH   = 13;
  localparam int QW       = 28;

  // finite-difference path widths
  localparam int DIF_W    = CB + 1;
  localparam int FCRS_W   = CB + 5;
  localparam int T_W      = 2 * CB + 7;
  localparam int T_SHIFT  = 2 * F - 24;
  localparam int T24_W    = T_W - T_SHIFT;
  localparam int SPLIT    = 18;
  localparam int HI_W     = T24_W - SPLIT;
  localparam int K_W      = 27;
  localparam int PH_W     = HI_W + K_W + 1;
  localparam int PL_W     = SPLIT + K_W;
  localparam int P_W      = 64;
  localparam int P_SH     = 36;

  // result format
  localparam int OUT_W    = 22;
  localparam logic signed [QW-1:0] OUT_MAX = QW'(2097151);
  localparam logic signed [QW-1:0] OUT_MIN = -QW'(2097152);

  // round(2^28 / pi)
  localparam logic [K_W-1:0] INV_PI_Q28 = K_W'(85445659);

  // configuration codes
  typedef enum logic {
    METHOD_LATTICE = 1'b0,
    METHOD_FINITE  = 1'b1
  } method_t;

  typedef logic signed [CB-1:0]     comp_t;
  typedef logic signed [CRS_W-1:0]  crs_comp_t;
  typedef logic signed [FCRS_W-1:0] fcrs_comp_t;

  typedef struct packed {
    comp_t z;
    comp_t y;
    comp_t x;
  } vec_t;

  typedef struct packed {
    crs_comp_t z;
    crs_comp_t y;
    crs_comp_t x;
  } crs_t;

  typedef struct packed {
    fcrs_comp_t z;
    fcrs_comp_t y;
    fcrs_comp_t x;
  } fcrs_t;

  // split a packed spin word into its components
  function automatic vec_t unpack(input logic [SPIN_W-1:0] w);
    vec_t v;
    v.x = w[CB-1:0];
    v.y = w[2*CB-1:CB];
    v.z = w[3*CB-1:2*CB];
    return v;
  endfunction

  // exact dot product
  function automatic logic signed [DOT_W-1:0] dot_f(input vec_t a, input vec_t b);
    logic signed [DOT_W-1:0] s;
    s = a.x * b.x + a.y * b.y + a.z * b.z;
    return s;
  endfunction

  // cross product floored back to F fraction bits
  function automatic crs_t cross_floor(input vec_t a, input vec_t b);
    logic signed [2*CB:0] px;
    logic signed [2*CB:0] py;
    logic signed [2*CB:0] pz;
    crs_t r;
    px = a.y * b.z - a.z * b.y;
    py = a.z * b.x - a.x * b.z;
    pz = a.x * b.y - a.y * b.x;
    r.x = CRS_W'(px >>> F);
    r.y = CRS_W'(py >>> F);
    r.z = CRS_W'(pz >>> F);
    return r;
  endfunction

  // arctangent of 2^-i in units of pi/2^31, truncated
  function automatic logic [30:0] atan_at(input int i);
    logic [30:0] v;
    unique case (i)
      0:       v = 31'd536870912;
      1:       v = 31'd316933405;
      2:       v = 31'd167458907;
      3:       v = 31'd85004756;
      4:       v = 31'd42667331;
      5:       v = 31'd21354465;
      6:       v = 31'd10679838;
      7:       v = 31'd5340245;
      8:       v = 31'd2670163;
      9:       v = 31'd1335086;
      10:      v = 31'd667544;
      11:      v = 31'd333772;
      12:      v = 31'd166886;
      13:      v = 31'd83443;
      14:      v = 31'd41721;
      15:      v = 31'd20860;
      16:      v = 31'd10430;
      17:      v = 31'd5215;
      18:      v = 31'd2607;
      19:      v = 31'd1303;
      20:      v = 31'd651;
      21:      v = 31'd325;
      22:      v = 31'd162;
      23:      v = 31'd81;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/ltc_ifs.sv
// handshake channels of the topological charge unit

// site transfer: centre spin and its four neighbors
interface ltc_site_if;
  logic                       valid;
  logic                       ready;
  logic [ltc_pkg::SPIN_W-1:0] centre_spin;
  logic [ltc_pkg::SPIN_W-1:0] left_spin;
  logic [ltc_pkg::SPIN_W-1:0] right_spin;
  logic [ltc_pkg::SPIN_W-1:0] up_spin;
  logic [ltc_pkg::SPIN_W-1:0] down_spin;
  modport source (output valid, centre_spin, left_spin, right_spin, up_spin, down_spin,
                  input ready);
  modport sink   (input valid, centre_spin, left_spin, right_spin, up_spin, down_spin,
                  output ready);
endinterface

// result transfer: charge density
interface ltc_charge_if;
  logic                             valid;
  logic                             ready;
  logic signed [ltc_pkg::OUT_W-1:0] charge_density;
  modport source (output valid, charge_density, input ready);
  modport sink   (input valid, charge_density, output ready);
endinterface

// configuration write: method select
interface ltc_cfg_if;
  logic valid;
  logic ready;
  logic method;
  modport source (output valid, method, input ready);
  modport sink   (input valid, method, output ready);
endinterface

### hdl/lattice_topological_charge_unit.sv
// topological charge density of one lattice site, fully pipelined
//
// One site is accepted per clock and one charge density leaves per clock. The pipeline has
// one stage of cross and dot products, one of triple products and denominators, one of
// CORDIC pre-rotation and the finite-mode partial products, one stage per CORDIC
// iteration, and the output register, ahead of which the four solid angles are summed and
// rounded and the selected result is saturated. The whole pipeline moves together and holds
// when the output is full and not taken, so no site is lost or repeated. method selects
// the lattice solid-angle form (0) or the finite-difference form (1); the user must write
// it only while no site is in flight, and the block itself does not enforce this.
module lattice_topological_charge_unit #(
  parameter int CORDIC_STAGES = ltc_pkg::CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ltc_site_if.sink   site,
  ltc_charge_if.source charge,
  ltc_cfg_if.sink    cfg
);
  import ltc_pkg::*;

  localparam int DEPTH = CORDIC_STAGES + 4;

  logic                 method;
  logic [DEPTH-1:0]     vld;
  logic                 adv;

  // stage 1
  vec_t                 s1_c;
  crs_t                 s1_crs [4];
  logic signed [DOT_W-1:0] s1_dab [4];
  logic signed [DOT_W-1:0] s1_dac [4];
  logic signed [DOT_W-1:0] s1_dbc [4];
  fcrs_t                s1_fcrs;

  // stage 2
  logic signed [NUM_W-1:0] s2_num [4];
  logic signed [DEN_W-1:0] s2_den [4];
  logic signed [T24_W-1:0] s2_t24;

  // stage 3 and cordic chain
  logic signed [CW-1:0]    cx [0:CORDIC_STAGES][4];
  logic signed [CW-1:0]    cy [0:CORDIC_STAGES][4];
  logic signed [ANG_W-1:0] cz [0:CORDIC_STAGES][4];
  logic                    zf [0:CORDIC_STAGES][4];
  logic signed [PH_W-1:0]  s3_ph;
  logic [PL_W-1:0]         s3_pl;
  logic signed [QW-1:0]    qf [1:CORDIC_STAGES];

  // stage 1 combinational inputs
  vec_t c_in;
  vec_t l_in;
  vec_t r_in;
  vec_t u_in;
  vec_t d_in;
  vec_t b_in [4];
  vec_t k_in [4];

  // final stage combinational
  logic signed [SUM_W-1:0] ang_sum;
  logic signed [QW-1:0]    q_lat;
  logic signed [QW-1:0]    q_sel;
  logic signed [OUT_W-1:0] q_sat;

  // pipeline advances when the output slot is free or being taken
  assign adv        = !vld[DEPTH-1] || charge.ready;
  assign site.ready = adv;
  assign cfg.ready  = 1'b1;
  assign charge.valid = vld[DEPTH-1];

  // method register
  always_ff @(posedge clk) begin
    if (rst) begin
      method <= METHOD_LATTICE;
    end else if (cfg.valid) begin
      method <= cfg.method;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], site.valid};
    end
  end

  // unpack and pair the triangle edges
  always_comb begin
    c_in = unpack(site.centre_spin);
    l_in = unpack(site.left_spin);
    r_in = unpack(site.right_spin);
    u_in = unpack(site.up_spin);
    d_in = unpack(site.down_spin);
    b_in[0] = r_in;  k_in[0] = u_in;
    b_in[1] = u_in;  k_in[1] = l_in;
    b_in[2] = l_in;  k_in[2] = d_in;
    b_in[3] = d_in;  k_in[3] = r_in;
  end

  // stage 1: cross products and pairwise dots
  always_ff @(posedge clk) begin
    logic signed [DIF_W-1:0] ax;
    logic signed [DIF_W-1:0] ay;
    logic signed [DIF_W-1:0] az;
    logic signed [DIF_W-1:0] bx;
    logic signed [DIF_W-1:0] by;
    logic signed [DIF_W-1:0] bz;
    logic signed [2*DIF_W:0] px;
    logic signed [2*DIF_W:0] py;
    logic signed [2*DIF_W:0] pz;
    if (adv) begin
      s1_c <= c_in;
      for (int k = 0; k < 4; k++) begin
        s1_crs[k] <= cross_floor(b_in[k], k_in[k]);
        s1_dab[k] <= dot_f(c_in, b_in[k]);
        s1_dac[k] <= dot_f(c_in, k_in[k]);
        s1_dbc[k] <= dot_f(b_in[k], k_in[k]);
      end
      ax = DIF_W'(r_in.x) - DIF_W'(l_in.x);
      ay = DIF_W'(r_in.y) - DIF_W'(l_in.y);
      az = DIF_W'(r_in.z) - DIF_W'(l_in.z);
      bx = DIF_W'(u_in.x) - DIF_W'(d_in.x);
      by = DIF_W'(u_in.y) - DIF_W'(d_in.y);
      bz = DIF_W'(u_in.z) - DIF_W'(d_in.z);
      px = ay * bz - az * by;
      py = az * bx - ax * bz;
      pz = ax * by - ay * bx;
      s1_fcrs.x <= FCRS_W'(px >>> F);
      s1_fcrs.y <= FCRS_W'(py >>> F);
      s1_fcrs.z <= FCRS_W'(pz >>> F);
    end
  end

  // stage 2: triple products and denominators
  always_ff @(posedge clk) begin
    logic signed [T_W-1:0] t;
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s2_num[k] <= s1_c.x * s1_crs[k].x + s1_c.y * s1_crs[k].y + s1_c.z * s1_crs[k].z;
        s2_den[k] <= (DEN_W'(1) <<< (2 * F)) + DEN_W'(s1_dab[k]) + DEN_W'(s1_dac[k])
                     + DEN_W'(s1_dbc[k]);
      end
      t = s1_c.x * s1_fcrs.x + s1_c.y * s1_fcrs.y + s1_c.z * s1_fcrs.z;
      s2_t24 <= T24_W'(t >>> T_SHIFT);
    end
  end

  // stage 3: fold into the right half plane, finite-mode partial products
  always_ff @(posedge clk) begin
    logic signed [HI_W-1:0] hi;
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        zf[0][k] <= (s2_num[k] == '0) && (s2_den[k] == '0);
        if (s2_den[k] < 0) begin
          cx[0][k] <= -CW'(s2_den[k]);
          cy[0][k] <= -CW'(s2_num[k]);
          cz[0][k] <= (s2_num[k] >= 0) ? (ANG_W'(1) <<< 31) : -(ANG_W'(1) <<< 31);
        end else begin
          cx[0][k] <= CW'(s2_den[k]);
          cy[0][k] <= CW'(s2_num[k]);
          cz[0][k] <= '0;
        end
      end
      hi = s2_t24[T24_W-1:SPLIT];
      s3_ph <= hi * $signed({1'b0, INV_PI_Q28});
      s3_pl <= s2_t24[SPLIT-1:0] * INV_PI_Q28;
    end
  end

  // cordic iterations, one per register stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          zf[i+1][k] <= zf[i][k];
          if (!cy[i][k][CW-1]) begin
            cx[i+1][k] <= cx[i][k] + (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] - (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] + $signed(ANG_W'(atan_at(i)));
          end else begin
            cx[i+1][k] <= cx[i][k] - (cy[i][k] >>> i);
            cy[i+1][k] <= cy[i][k] + (cx[i][k] >>> i);
            cz[i+1][k] <= cz[i][k] - $signed(ANG_W'(atan_at(i)));
          end
        end
      end
    end
  end

  // finite-mode result: recombine partial products and round, then ride along
  always_ff @(posedge clk) begin
    logic signed [P_W-1:0] p;
    if (adv) begin
      p = (P_W'(s3_ph) <<< SPLIT) + $signed(P_W'(s3_pl)) + (P_W'(1) <<< (P_SH - 1));
      qf[1] <= QW'(p >>> P_SH);
    end
  end

  for (genvar i = 1; i < CORDIC_STAGES; i++) begin : g_qf
    always_ff @(posedge clk) begin
      if (adv) begin
        qf[i+1] <= qf[i];
      end
    end
  end

  // sum the four solid angles, round, select and saturate
  always_comb begin
    ang_sum = '0;
    for (int k = 0; k < 4; k++) begin
      if (!zf[CORDIC_STAGES][k]) begin
        ang_sum = ang_sum + SUM_W'(cz[CORDIC_STAGES][k]);
      end
    end
    q_lat = QW'((ang_sum + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH);
    q_sel = (method == METHOD_FINITE) ? qf[CORDIC_STAGES] : q_lat;
    priority if (q_sel > OUT_MAX) begin
      q_sat = OUT_MAX[OUT_W-1:0];
    end else if (q_sel < OUT_MIN) begin
      q_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      q_sat = q_sel[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      charge.charge_density <= q_sat;
    end
  end

`ifndef ASSERT_OFF
  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !charge.valid)
    else $error("result valid right after reset");

  // the input stalls only behind a full, untaken output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !site.ready |-> (charge.valid && !charge.ready))
    else $error("input stalled without output back-pressure");

  // a configuration transfer lands in the method register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (method == $past(cfg.method)))
    else $error("method register missed a write");
`endif

endmodule
